@@ rtl/mjfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mjfd_pkg: shared definitions for the marked JPEG frame deframer
// Window geometry, marker and pattern bytes, frame phases and status codes.
// ----------------------------------------------------------------------------
package mjfd_pkg;

   localparam int unsigned WinLen  = 13;
   localparam int unsigned HeldLen = WinLen - 1;
   localparam int unsigned TailLen = 9;
   localparam int unsigned TailPos = 3;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] count_type;
   typedef logic [1:0] phase_type;
   typedef logic [2:0] status_type;

   localparam byte_type  MarkFf   = 8'hFF;
   localparam byte_type  MarkSoi  = 8'hD8;
   localparam byte_type  MarkEoi  = 8'hD9;
   localparam count_type HdrCount = 4'd11;
   localparam count_type FullFill = count_type'(HeldLen);

   localparam phase_type PhIdle    = 2'd0;
   localparam phase_type PhHeader  = 2'd1;
   localparam phase_type PhPayload = 2'd2;
   localparam phase_type PhEnding  = 2'd3;

   localparam status_type StNone     = 3'd0;
   localparam status_type StGood     = 3'd1;
   localparam status_type StSumBad   = 3'd2;
   localparam status_type StNoTail   = 3'd3;
   localparam status_type StAbortHdr = 3'd4;
   localparam status_type StAbortSoi = 3'd5;

   localparam byte_type HdrPat [WinLen] = '{
      8'h3C, 8'h42, 8'h69, 8'h6E, 8'h67, 8'h6F, 8'h53,
      8'h74, 8'h61, 8'h72, 8'h74, 8'hFF, 8'hD8
   };

   localparam byte_type TailPat [TailLen] = '{
      8'h42, 8'h69, 8'h6E, 8'h67, 8'h6F, 8'h45, 8'h6E, 8'h64, 8'h3E
   };

endpackage

@@ rtl/marked_jpeg_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// marked_jpeg_frame_deframer: marked JPEG frame deframer
// Tags each received byte with its frame membership, reports the verdict of
// every closed frame on its D9 byte and flags a frame that is abandoned.
//
// Usage:
//   req_* carries one received byte per beat, rsp_* one tagged byte per beat.
//   The block holds the last 12 bytes; together with the byte being accepted
//   they form the 13-byte window that is searched for header, markers and
//   tail. The first 12 beats after reset give no result; from then on every
//   accepted beat releases the oldest byte of the window.
//   Latency: the result for a byte is shown in the cycle after the beat that
//   brings in the byte 12 positions later.
//   Throughput: one beat per cycle while results are taken; all compares of the
//   window and the 8-bit sum are combinational from the held bytes to the result register.
//   Reset empties the window, closes any frame and drops a waiting result.
//   A stalled receiver holds the result register; req_ready stays high while
//   that register is empty or is being taken in the same cycle.
// ----------------------------------------------------------------------------
module marked_jpeg_frame_deframer
   import mjfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_in_frame,
   output logic       rsp_frame_first,
   output logic [2:0] rsp_frame_status
);

   byte_type   win_ff [HeldLen];
   count_type  fill_ff, fill_in;
   phase_type  phase_ff, phase_in;
   count_type  cnt_ff, cnt_in;
   byte_type   sum_ff, sum_in;
   status_type verdict_ff, verdict_in;

   logic       out_valid_ff, out_valid_in;
   byte_type   out_data_ff;
   logic       out_inf_ff, out_inf_in;
   logic       out_first_ff, out_first_in;
   status_type out_status_ff, out_status_in;

   byte_type   win [WinLen];
   logic       accept;
   logic       full;
   logic       hdr_hit;
   logic       tail_hit;
   byte_type   end_sum;
   count_type  cnt_dec;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (fill_ff == FullFill);

   always_comb begin
      for (int i = 0; i < HeldLen; i++) begin
         win[i] = win_ff[i];
      end
      win[HeldLen] = req_rx_byte;
   end

   always_comb begin
      hdr_hit = 1'b1;
      for (int i = 0; i < WinLen; i++) begin
         if (win[i] != HdrPat[i]) begin
            hdr_hit = 1'b0;
         end
      end
      tail_hit = 1'b1;
      for (int i = 0; i < TailLen; i++) begin
         if (win[TailPos + i] != TailPat[i]) begin
            tail_hit = 1'b0;
         end
      end
   end

   assign end_sum = sum_ff + MarkFf + MarkEoi;
   assign cnt_dec = (cnt_ff != 4'd0) ? cnt_ff - 4'd1 : cnt_ff;

   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      verdict_in    = verdict_ff;
      out_inf_in    = 1'b0;
      out_first_in  = 1'b0;
      out_status_in = StNone;
      case (phase_ff)
         PhEnding: begin
            out_inf_in    = 1'b1;
            out_status_in = verdict_ff;
            verdict_in    = StNone;
            phase_in      = PhIdle;
         end
         PhHeader: begin
            cnt_in = cnt_dec;
            if (cnt_dec == 4'd0) begin
               phase_in     = PhPayload;
               out_inf_in   = 1'b1;
               out_first_in = 1'b1;
               sum_in       = win[0];
            end
         end
         default: begin
            if (hdr_hit) begin
               if (phase_ff == PhPayload) begin
                  out_status_in = StAbortHdr;
               end
               phase_in = PhHeader;
               cnt_in   = HdrCount;
            end else if (phase_ff == PhPayload) begin
               if (win[0] == MarkFf && win[1] == MarkEoi) begin
                  if (!tail_hit) begin
                     verdict_in = StNoTail;
                  end else if (end_sum == win[2]) begin
                     verdict_in = StGood;
                  end else begin
                     verdict_in = StSumBad;
                  end
                  phase_in   = PhEnding;
                  out_inf_in = 1'b1;
               end else if (win[0] == MarkFf && win[1] == MarkSoi) begin
                  phase_in      = PhIdle;
                  out_status_in = StAbortSoi;
               end else begin
                  sum_in     = sum_ff + win[0];
                  out_inf_in = 1'b1;
               end
            end else begin
               phase_in = PhIdle;
            end
         end
      endcase
   end

   assign fill_in      = full ? fill_ff : fill_ff + 4'd1;
   assign out_valid_in = accept ? full : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         phase_ff     <= PhIdle;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         verdict_ff   <= StNone;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            fill_ff <= fill_in;
            if (full) begin
               phase_ff   <= phase_in;
               cnt_ff     <= cnt_in;
               sum_ff     <= sum_in;
               verdict_ff <= verdict_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < HeldLen; i++) begin
            win_ff[i] <= win[i + 1];
         end
         if (full) begin
            out_data_ff   <= win[0];
            out_inf_ff    <= out_inf_in;
            out_first_ff  <= out_first_in;
            out_status_ff <= out_status_in;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_data_byte    = out_data_ff;
   assign rsp_in_frame     = out_inf_ff;
   assign rsp_frame_first  = out_first_ff;
   assign rsp_frame_status = out_status_ff;

endmodule

@@ rtl/mjfd_checker.sv @@
// ----------------------------------------------------------------------------
// mjfd_checker: port-level checks for the marked JPEG frame deframer
// Watches the result channel for consistent frame tagging and flow.
// ----------------------------------------------------------------------------
module mjfd_checker
   import mjfd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_in_frame,
   input logic       rsp_frame_first,
   input logic [2:0] rsp_frame_status
);

   first_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_first |->
         rsp_in_frame && rsp_frame_status == StNone && rsp_data_byte == MarkFf)
      else $error("frame start beat not tagged as payload FF");

   abort_out_of_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_status == StAbortHdr || rsp_frame_status == StAbortSoi)
         |-> !rsp_in_frame)
      else $error("abandon beat tagged as payload");

   verdict_on_eoi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_status == StGood || rsp_frame_status == StSumBad ||
         rsp_frame_status == StNoTail) |-> rsp_in_frame && rsp_data_byte == MarkEoi)
      else $error("frame verdict not on an in-frame D9 beat");

   ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte) &&
         $stable(rsp_in_frame) && $stable(rsp_frame_first) &&
         $stable(rsp_frame_status))
      else $error("stalled result beat changed");

endmodule

bind marked_jpeg_frame_deframer mjfd_checker u_mjfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_data_byte    (rsp_data_byte),
   .rsp_in_frame     (rsp_in_frame),
   .rsp_frame_first  (rsp_frame_first),
   .rsp_frame_status (rsp_frame_status)
);
